@@ src/wlbc_pkg.sv @@
package wlbc_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int STAMP_BITS_DEF = 32;
	localparam int TAG_W          = 64;
	localparam int CNT_W          = 7;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_PROBE   = 3'd1;
	localparam logic [2:0] OP_ACCESS  = 3'd2;
	localparam logic [2:0] OP_FLUSH   = 3'd3;
	localparam logic [2:0] OP_HARVEST = 3'd4;

	localparam logic [2:0] K_INSERTED  = 3'd0;
	localparam logic [2:0] K_FULL      = 3'd1;
	localparam logic [2:0] K_DUPLICATE = 3'd2;
	localparam logic [2:0] K_HIT       = 3'd3;
	localparam logic [2:0] K_MISS      = 3'd4;
	localparam logic [2:0] K_FLUSHED   = 3'd5;
	localparam logic [2:0] K_EVICTED   = 3'd6;
	localparam logic [2:0] K_NONE      = 3'd7;

	localparam logic REG_FREE_MIN = 1'b0;
	localparam logic REG_FREE_MAX = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_FLUSH,
		ST_FLUSH_WAIT,
		ST_HSEL,
		ST_HSEL_LAST,
		ST_HEMIT,
		ST_HEMIT_WAIT,
		ST_OUT
	} state_t;

	// Result register status presented to the datapath.
	typedef struct packed {
		logic busy;
		logic full;
	} out_stat_t;

endpackage

@@ src/watermark_lru_block_cache_top.sv @@
// Channel | Signals                                     | Transfer when
// in      | valid_in stall_in operation block_address dirty_in | valid_in && !stall_in
// out     | valid stall kind address_out free_count last | valid && !stall
// cfg     | psel penable pwrite paddr pwdata prdata pready | psel&&penable&&pwrite
// Each item first scans the table memory, one entry a cycle, to find the tag, the lowest
// free slot and the free count, and then decides. Flush then reads each entry in turn and
// emits and cleans it in a wait state if it is dirty. Harvest of n entries adds n selection
// passes and n emission passes, plus one more selection pass when the clean entries run out.
// The table memory is single-port.
// Reset clears the valid bits, the counter and the control and configuration registers at
// once; the datapath registers are not reset. A stalled output holds the walk; the next input
// is taken once all results of the current item have been delivered.
module watermark_lru_block_cache_top
	import wlbc_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int STAMP_BITS = STAMP_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	output logic             stall_in,
	input  logic [2:0]       operation,
	input  logic [TAG_W-1:0] block_address,
	input  logic             dirty_in,
	output logic             valid,
	input  logic             stall,
	output logic [2:0]       kind,
	output logic [TAG_W-1:0] address_out,
	output logic [CNT_W-1:0] free_count,
	output logic             last,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int EW = TAG_W + 1 + STAMP_BITS;
	localparam int KW = STAMP_BITS + IW;

	// Table memory: tag, dirty, stamp per entry. Valid bits in flip-flops.
	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_s1;
	logic [CAPACITY-1:0] valid_q;
	logic [CAPACITY-1:0] chosen_q;

	logic [CNT_W-1:0] free_min_q, free_max_q;
	logic [STAMP_BITS-1:0] counter_q;

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic [TAG_W-1:0] addr_q;
	logic dirty_q;
	logic [IW-1:0] ptr_q, rd_idx_s1;
	logic rd_en;
	logic [IW-1:0] rd_addr;

	logic hit_q, any_free_q, any_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, best_idx_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] want_q, got_q;
	logic [CNT_W-1:0] want_c;
	logic [KW-1:0] best_key_q;
	logic best_ok_q;

	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic o_load;
	logic [2:0] o_kind;
	logic [TAG_W-1:0] o_addr;
	logic [CNT_W-1:0] o_free;
	logic o_last;
	out_stat_t ostat;

	// Extra capture of the hit entry and best entry tags.
	logic [TAG_W-1:0] hit_tag_q, best_tag_q;
	logic hit_dirty_q;
	logic [CAPACITY-1:0] dirty_map_q;
	logic flush_tail;

	// Decoded fields of the entry just read.
	logic [TAG_W-1:0] r_tag;
	logic r_dirty;
	logic [STAMP_BITS-1:0] r_stamp;
	logic r_valid;
	logic [KW-1:0] r_key;
	assign r_tag   = rd_s1[EW-1 -: TAG_W];
	assign r_dirty = rd_s1[STAMP_BITS];
	assign r_stamp = rd_s1[STAMP_BITS-1:0];
	assign r_valid = valid_q[rd_idx_s1];
	assign r_key   = {r_stamp, rd_idx_s1};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_s1     <= mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	// Configuration.
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_min_q <= CNT_W'(8);
			free_max_q <= CNT_W'(16);
		end else if (cfg_wr && paddr[2] == REG_FREE_MIN && paddr[1:0] == 2'b00) begin
			free_min_q <= pwdata[CNT_W-1:0];
		end else if (cfg_wr && paddr[2] == REG_FREE_MAX && paddr[1:0] == 2'b00) begin
			free_max_q <= pwdata[CNT_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FREE_MIN && paddr[1:0] == 2'b00) prdata[CNT_W-1:0] = free_min_q;
		else if (paddr[2] == REG_FREE_MAX && paddr[1:0] == 2'b00) prdata[CNT_W-1:0] = free_max_q;
	end

	logic in_xfer;
	logic ptr_end;
	assign stall_in = (state_q != ST_IDLE);
	assign in_xfer  = valid_in && !stall_in;
	assign ptr_end  = (ptr_q == IW'(CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign want_c = (free_q < free_min_q && free_max_q > free_q) ? free_max_q - free_q : '0;

	// Selection compare: clean, valid, not yet chosen, smaller key.
	logic sel_cand;
	assign sel_cand = r_valid && !r_dirty && !chosen_q[rd_idx_s1] &&
		(!best_ok_q || r_key < best_key_q);
	// Emission compare: chosen, largest key.
	logic emit_cand;
	assign emit_cand = chosen_q[rd_idx_s1] && (!best_ok_q || r_key > best_key_q);
	// The last entry of an emission pass is weighed in the cycle that emits.
	logic [IW-1:0] ev_idx;
	logic [TAG_W-1:0] ev_tag;
	assign ev_idx = emit_cand ? rd_idx_s1 : best_idx_q;
	assign ev_tag = emit_cand ? r_tag : best_tag_q;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_s1;
		o_load  = 1'b0;
		o_kind  = K_NONE;
		o_addr  = addr_q;
		o_free  = free_q;
		o_last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (ptr_end) state_d = ST_SCAN_LAST;
			end
			ST_SCAN_LAST: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!ostat.full) begin
					case (op_q)
						OP_INSERT: begin
							o_load = 1'b1;
							state_d = ST_OUT;
							if (!any_free_q) o_kind = K_FULL;
							else if (hit_q) o_kind = K_DUPLICATE;
							else begin
								o_kind  = K_INSERTED;
								o_free  = free_q - CNT_W'(1);
								wr_en   = 1'b1;
								wr_addr = free_idx_q;
								wr_data = {addr_q, dirty_q, counter_q};
							end
						end
						OP_PROBE, OP_ACCESS: begin
							o_load = 1'b1;
							state_d = ST_OUT;
							o_kind = hit_q ? K_HIT : K_MISS;
							if (hit_q && op_q == OP_ACCESS) begin
								wr_en   = 1'b1;
								wr_addr = hit_idx_q;
								wr_data = {hit_tag_q, hit_dirty_q, counter_q};
							end
						end
						OP_FLUSH: state_d = ST_FLUSH;
						OP_HARVEST: begin
							if (want_c == '0) begin
								o_load = 1'b1;
								o_addr = '0;
								state_d = ST_OUT;
							end else begin
								state_d = ST_HSEL;
							end
						end
						default: begin
							o_load = 1'b1;
							o_addr = '0;
							state_d = ST_OUT;
						end
					endcase
				end
			end
			// Flush: read an entry, then emit/clean it in the wait cycle.
			ST_FLUSH: begin
				rd_en = 1'b1;
				state_d = ST_FLUSH_WAIT;
			end
			ST_FLUSH_WAIT: begin
				if (!ostat.full) begin
					if (r_valid && r_dirty) begin
						o_load  = 1'b1;
						o_kind  = K_FLUSHED;
						o_addr  = r_tag;
						o_last  = !flush_tail;
						wr_en   = 1'b1;
						wr_addr = rd_idx_s1;
						wr_data = {r_tag, 1'b0, r_stamp};
					end else if (ptr_end && !any_q) begin
						o_load = 1'b1;
						o_addr = '0;
					end
					if (ptr_end) state_d = ST_OUT;
					else state_d = ST_FLUSH;
				end
			end
			ST_HSEL: begin
				rd_en = 1'b1;
				if (ptr_end) state_d = ST_HSEL_LAST;
			end
			ST_HSEL_LAST: begin
				if (!best_ok_q && !sel_cand && got_q == '0) begin
					// No clean entry at all: the harvest reports none.
					if (!ostat.full) begin
						o_load = 1'b1;
						o_addr = '0;
						state_d = ST_OUT;
					end
				end else if (!best_ok_q || got_q + CNT_W'(1) == want_q) begin
					// A selection pass that finds nothing, or that reaches the wanted count, ends the choosing.
					state_d = ST_HEMIT;
				end else begin
					state_d = ST_HSEL;
				end
			end
			ST_HEMIT: begin
				rd_en = 1'b1;
				if (ptr_end) state_d = ST_HEMIT_WAIT;
			end
			ST_HEMIT_WAIT: begin
				if (!ostat.full) begin
					o_load = 1'b1;
					o_kind = K_EVICTED;
					o_addr = ev_tag;
					o_free = free_q + CNT_W'(1);
					o_last = (got_q == CNT_W'(1));
					state_d = (got_q == CNT_W'(1)) ? ST_OUT : ST_HEMIT;
				end
			end
			ST_OUT: begin
				if (!ostat.busy || !stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	logic scan_rd;
	assign scan_rd = (state_q == ST_SCAN && ptr_q != '0) || state_q == ST_SCAN_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			chosen_q  <= '0;
			counter_q <= '0;
			ptr_q     <= '0;
			best_ok_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				ptr_q <= '0;
				chosen_q <= '0;
			end
			if (state_q == ST_SCAN || state_q == ST_HSEL || state_q == ST_HEMIT) begin
				ptr_q <= ptr_end ? '0 : ptr_q + IW'(1);
			end
			if (state_q == ST_FLUSH_WAIT && !ostat.full) begin
				ptr_q <= ptr_end ? '0 : ptr_q + IW'(1);
			end
			if (state_q == ST_DECIDE && !ostat.full) begin
				best_ok_q <= 1'b0;
				if (op_q == OP_INSERT && any_free_q && !hit_q) begin
					valid_q[free_idx_q] <= 1'b1;
					counter_q <= counter_q + STAMP_BITS'(1);
				end
				if (op_q == OP_ACCESS && hit_q) counter_q <= counter_q + STAMP_BITS'(1);
			end
			if (state_q == ST_HSEL && ptr_q != '0) begin
				if (sel_cand) best_ok_q <= 1'b1;
			end
			if (state_q == ST_HSEL_LAST) begin
				if (best_ok_q || sel_cand) chosen_q[sel_cand ? rd_idx_s1 : best_idx_q] <= 1'b1;
				best_ok_q <= 1'b0;
			end
			if (state_q == ST_HEMIT && ptr_q != '0) begin
				if (emit_cand) best_ok_q <= 1'b1;
			end
			if (state_q == ST_HEMIT_WAIT && !ostat.full) begin
				chosen_q[ev_idx] <= 1'b0;
				valid_q[ev_idx]  <= 1'b0;
				best_ok_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	logic emit_rd;
	assign emit_rd = (state_q == ST_HEMIT && ptr_q != '0);
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q       <= operation;
			addr_q     <= block_address;
			dirty_q    <= dirty_in;
			hit_q      <= 1'b0;
			any_free_q <= 1'b0;
			any_q      <= 1'b0;
			free_q     <= '0;
			got_q      <= '0;
		end
		if (scan_rd) begin
			if (r_valid && r_tag == addr_q && !hit_q) begin
				hit_q       <= 1'b1;
				hit_idx_q   <= rd_idx_s1;
				hit_tag_q   <= r_tag;
				hit_dirty_q <= r_dirty;
			end
			if (!r_valid) begin
				free_q <= free_q + CNT_W'(1);
				if (!any_free_q) begin
					any_free_q <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end
		end
		if (state_q == ST_DECIDE) want_q <= want_c;
		if (state_q == ST_FLUSH_WAIT && !ostat.full && r_valid && r_dirty) any_q <= 1'b1;
		if (((state_q == ST_HSEL && ptr_q != '0) || state_q == ST_HSEL_LAST) && sel_cand) begin
			best_key_q <= r_key;
			best_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_HSEL_LAST && (best_ok_q || sel_cand)) got_q <= got_q + CNT_W'(1);
		if (emit_rd && emit_cand) begin
			best_key_q <= r_key;
			best_idx_q <= rd_idx_s1;
			best_tag_q <= r_tag;
		end
		if (state_q == ST_HEMIT_WAIT && !ostat.full) begin
			got_q  <= got_q - CNT_W'(1);
			free_q <= free_q + CNT_W'(1);
		end
	end

	// Dirty map: lets flush mark its final result without a look-ahead read.
	always_ff @(posedge clk) begin
		if (scan_rd) dirty_map_q[rd_idx_s1] <= r_valid && r_dirty;
	end
	always_comb begin
		flush_tail = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IW'(i) > rd_idx_s1 && dirty_map_q[i]) flush_tail = 1'b1;
		end
	end

	wlbc_outreg u_out (
		.clk(clk), .arst_n(arst_n), .load(o_load),
		.kind_d(o_kind), .addr_d(o_addr), .free_d(o_free), .last_d(o_last),
		.stat(ostat), .valid(valid), .stall(stall),
		.kind(kind), .address_out(address_out), .free_count(free_count), .last(last)
	);

`ifndef ASSERT_OFF
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> stall_in)
		else $error("input taken while busy");
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> free_q <= CNT_W'(CAPACITY))
		else $error("free count out of range");
	a_evict_chosen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEMIT_WAIT && !ostat.full) |-> chosen_q[ev_idx])
		else $error("evicting an entry not chosen");
`endif

endmodule

@@ src/wlbc_outreg.sv @@
module wlbc_outreg
	import wlbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [2:0]       kind_d,
	input  logic [TAG_W-1:0] addr_d,
	input  logic [CNT_W-1:0] free_d,
	input  logic             last_d,
	output out_stat_t        stat,
	output logic             valid,
	input  logic             stall,
	output logic [2:0]       kind,
	output logic [TAG_W-1:0] address_out,
	output logic [CNT_W-1:0] free_count,
	output logic             last
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind        <= kind_d;
			address_out <= addr_d;
			free_count  <= free_d;
			last        <= last_d;
		end
	end

	assign valid     = valid_q;
	assign stat.full = valid_q && stall;
	assign stat.busy = valid_q;

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(valid_q && stall))
		else $error("result register overwritten while held");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && stall) |=> valid_q && $stable(address_out) && $stable(kind))
		else $error("held result changed");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !stall && !load) |=> !valid_q)
		else $error("taken result repeated");
`endif

endmodule
